@@ hdl/kpt_pkg.sv @@
// Package for the keyed priority table: sizes, opcodes, slot and transaction types.
// Depends on nothing; the comparator and the top level import it.
`default_nettype none

package kpt_pkg;

    // Table sizing
    localparam int TABLE_DEPTH    = 16;
    localparam int VALUE_WIDTH    = 32;
    localparam int PRIORITY_WIDTH = 16;
    localparam int IDX_W          = $clog2(TABLE_DEPTH);
    localparam int CNT_W          = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_W         = VALUE_WIDTH + PRIORITY_WIDTH;

    // Operation codes; the remaining code performs no operation.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    typedef struct packed {
        logic        [1:0]                opcode;
        logic signed [VALUE_WIDTH-1:0]    key_value;
        logic signed [PRIORITY_WIDTH-1:0] new_priority;
    } request_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0]    top_value;
        logic signed [PRIORITY_WIDTH-1:0] top_priority;
        logic                             is_empty;
        logic        [CNT_W-1:0]          entry_total;
        logic        [CNT_W-1:0]          match_total;
        logic                             insert_dropped;
    } result_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0]    value;
        logic signed [PRIORITY_WIDTH-1:0] prio;
    } slot_t;

    // Control from the sequencer to the best-entry unit.
    typedef struct packed {
        logic clear;
        logic take;
    } best_ctl_t;

endpackage

`default_nettype wire

@@ hdl/kpt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the slot store of the keyed priority table.
`default_nettype none

module kpt_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [DATA_W-1:0]          wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [DATA_W-1:0]          rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/kpt_best.sv @@
// Shared priority comparator that tracks the earliest highest-priority entry.
// Depends on kpt_pkg.
`default_nettype none

module kpt_best (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire kpt_pkg::best_ctl_t                        ctl,
    input  wire logic signed [kpt_pkg::VALUE_WIDTH-1:0]    cand_value,
    input  wire logic signed [kpt_pkg::PRIORITY_WIDTH-1:0] cand_priority,
    output logic                                           best_valid,
    output logic signed [kpt_pkg::VALUE_WIDTH-1:0]         best_value,
    output logic signed [kpt_pkg::PRIORITY_WIDTH-1:0]      best_priority
);
    import kpt_pkg::*;

    logic                             valid_reg, valid_next;
    logic signed [VALUE_WIDTH-1:0]    value_reg, value_next;
    logic signed [PRIORITY_WIDTH-1:0] prio_reg, prio_next;
    logic                             wins;

    // A candidate wins only on a strictly greater priority, so ties keep the earlier entry.
    assign wins = !valid_reg || ($signed(cand_priority) > $signed(prio_reg));

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctl.clear) begin
            valid_next = 1'b0;
        end else if (ctl.take && wins) begin
            valid_next = 1'b1;
            value_next = cand_value;
            prio_next  = cand_priority;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign best_valid    = valid_reg;
    assign best_value    = value_reg;
    assign best_priority = prio_reg;

endmodule

`default_nettype wire

@@ hdl/keyed_priority_table.sv @@
// Top level of the keyed priority table: sequencer, slot RAM and best-entry unit.
// Depends on kpt_pkg, kpt_ram and kpt_best.
//
//  Channel  | Ports                      | Carries
//  ---------+----------------------------+-----------------------------------------
//  request  | s_valid, s_ready, s_data   | opcode, key_value, new_priority
//  result   | m_valid, m_ready, m_data   | top entry, empty flag, counts, drop flag
//
// A new request is accepted only in the idle step, so one transaction finishes before
// the next is taken; the slot scan reads the entries through the single read port of
// the slot RAM, one entry a cycle; an empty table skips the scan.
// Reset empties the table at once; slot contents are not cleared.
// A finished result waits in an output register; a stalled result channel holds
// the sequencer in its report step until the register is free.
`default_nettype none

module keyed_priority_table (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire kpt_pkg::request_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output kpt_pkg::result_t       m_data
);
    import kpt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_APPEND = 4'b0100,
        ST_REPORT = 4'b1000
    } state_t;

    state_t                           state_reg, state_next;
    logic [1:0]                       op_reg, op_next;
    logic signed [VALUE_WIDTH-1:0]    key_reg, key_next;
    logic signed [PRIORITY_WIDTH-1:0] pri_reg, pri_next;
    logic [CNT_W-1:0]                 occ_reg, occ_next;
    logic [CNT_W-1:0]                 rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]                 proc_cnt_reg, proc_cnt_next;
    logic [CNT_W-1:0]                 wr_cnt_reg, wr_cnt_next;
    logic [CNT_W-1:0]                 match_reg, match_next;
    logic                             rd_vld_reg, rd_vld_next;
    logic                             drop_reg, drop_next;
    logic                             m_valid_reg, m_valid_next;
    result_t                          out_reg, out_next;

    logic                             accept;
    logic                             issue;
    logic                             hit;
    logic                             out_free;
    logic                             ram_wr_en;
    logic [IDX_W-1:0]                 ram_wr_addr;
    slot_t                            ram_wr_data;
    slot_t                            ram_rd_data;
    best_ctl_t                        best_ctl;
    logic signed [VALUE_WIDTH-1:0]    cand_value;
    logic signed [PRIORITY_WIDTH-1:0] cand_priority;
    logic                             best_valid;
    logic signed [VALUE_WIDTH-1:0]    best_value;
    logic signed [PRIORITY_WIDTH-1:0] best_priority;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign issue    = (state_reg == ST_SCAN) && (rd_cnt_reg < occ_reg);
    assign hit      = (ram_rd_data.value == key_reg);
    assign out_free = !m_valid_reg || m_ready;

    // Slot store
    kpt_ram #(
        .DATA_W (SLOT_W),
        .DEPTH  (TABLE_DEPTH)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (issue),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // Best-entry comparator shared by every step of the scan
    kpt_best u_best (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (best_ctl),
        .cand_value    (cand_value),
        .cand_priority (cand_priority),
        .best_valid    (best_valid),
        .best_value    (best_value),
        .best_priority (best_priority)
    );

    // Sequencer: read slots in order, rewrite or compact them, append inserts, feed the comparator.
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        pri_next      = pri_reg;
        occ_next      = occ_reg;
        rd_cnt_next   = rd_cnt_reg;
        proc_cnt_next = proc_cnt_reg;
        wr_cnt_next   = wr_cnt_reg;
        match_next    = match_reg;
        rd_vld_next   = 1'b0;
        drop_next     = drop_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = wr_cnt_reg[IDX_W-1:0];
        ram_wr_data   = ram_rd_data;
        best_ctl      = '0;
        cand_value    = ram_rd_data.value;
        cand_priority = ram_rd_data.prio;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next        = s_data.opcode;
                    key_next       = s_data.key_value;
                    pri_next       = s_data.new_priority;
                    rd_cnt_next    = '0;
                    proc_cnt_next  = '0;
                    wr_cnt_next    = '0;
                    match_next     = '0;
                    drop_next      = 1'b0;
                    best_ctl.clear = 1'b1;
                    state_next     = (occ_reg == '0) ? ST_APPEND : ST_SCAN;
                end
            end

            ST_SCAN: begin
                if (issue) begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg) begin
                    proc_cnt_next = proc_cnt_reg + CNT_W'(1);
                    if (op_reg == OP_UPDATE) begin
                        best_ctl.take = 1'b1;
                        if (hit) begin
                            match_next       = match_reg + CNT_W'(1);
                            cand_priority    = pri_reg;
                            ram_wr_en        = 1'b1;
                            ram_wr_addr      = proc_cnt_reg[IDX_W-1:0];
                            ram_wr_data.prio = pri_reg;
                        end
                    end else if (op_reg == OP_DELETE) begin
                        if (hit) begin
                            match_next = match_reg + CNT_W'(1);
                        end else begin
                            best_ctl.take = 1'b1;
                            ram_wr_en     = 1'b1;
                            wr_cnt_next   = wr_cnt_reg + CNT_W'(1);
                        end
                    end else begin
                        best_ctl.take = 1'b1;
                    end
                    if (proc_cnt_reg + CNT_W'(1) == occ_reg) begin
                        state_next = ST_APPEND;
                    end
                end
            end

            ST_APPEND: begin
                cand_value    = key_reg;
                cand_priority = pri_reg;
                if (op_reg == OP_INSERT) begin
                    if (occ_reg < CNT_W'(TABLE_DEPTH)) begin
                        ram_wr_en         = 1'b1;
                        ram_wr_addr       = occ_reg[IDX_W-1:0];
                        ram_wr_data.value = key_reg;
                        ram_wr_data.prio  = pri_reg;
                        best_ctl.take     = 1'b1;
                        occ_next          = occ_reg + CNT_W'(1);
                    end else begin
                        drop_next = 1'b1;
                    end
                end else if (op_reg == OP_DELETE) begin
                    occ_next = wr_cnt_reg;
                end
                state_next = ST_REPORT;
            end

            ST_REPORT: begin
                if (out_free) begin
                    out_next.top_value      = best_valid ? best_value : '0;
                    out_next.top_priority   = best_valid ? best_priority : '0;
                    out_next.is_empty       = (occ_reg == '0);
                    out_next.entry_total    = occ_reg;
                    out_next.match_total    = match_reg;
                    out_next.insert_dropped = drop_reg;
                    m_valid_next            = 1'b1;
                    state_next              = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg       <= op_next;
        key_reg      <= key_next;
        pri_reg      <= pri_next;
        rd_cnt_reg   <= rd_cnt_next;
        proc_cnt_reg <= proc_cnt_next;
        wr_cnt_reg   <= wr_cnt_next;
        match_reg    <= match_next;
        drop_reg     <= drop_next;
        out_reg      <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // The table never holds more entries than it has slots.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(TABLE_DEPTH))
        else $error("occupancy beyond table depth");

    // Read data is only consumed while scanning.
    a_rd_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> (state_reg == ST_SCAN))
        else $error("slot read data outside the scan");

    // Compaction never writes ahead of the entry being processed.
    a_compact_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_wr_en && state_reg == ST_SCAN) |-> (ram_wr_addr <= proc_cnt_reg[IDX_W-1:0]))
        else $error("compaction write ahead of scan");

    // A reported empty flag agrees with the reported entry count.
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_reg.is_empty == (out_reg.entry_total == '0)))
        else $error("empty flag disagrees with entry count");

endmodule

`default_nettype wire
